@@ src/hsl2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB package
// Pixel types and fixed-point constants shared by the converter pipeline.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    localparam int unsigned HUE_IN_W  = 16;
    localparam int unsigned PCT_IN_W  = 8;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned PCT_W     = 7;   // clamped percent, 0..100
    localparam int unsigned HUE_W     = 9;   // reduced hue, 0..359
    localparam int unsigned TERM_W    = 14;  // hi/lo terms, 0..10000
    localparam int unsigned RAMP_W    = 20;  // ramp value, 0..600000
    localparam int unsigned SCALED_W  = 28;  // ramp * 255
    localparam int unsigned HUE_Q_W   = 8;   // hue / 360 quotient

    localparam int unsigned PCT_MAX     = 100;
    localparam int unsigned PCT_HALF    = 50;
    localparam int unsigned HUE_FULL    = 360;
    localparam int unsigned HUE_THIRD   = 120;
    localparam int unsigned HUE_TWO3    = 240;
    localparam int unsigned HUE_SIXTH   = 60;
    localparam int unsigned HUE_HALF    = 180;
    localparam int unsigned RAMP_FULL   = 600000;

    // floor(2^HUE_SHIFT / 360): quotient estimate is exact or one low
    localparam int unsigned HUE_SHIFT   = 24;
    localparam int unsigned HUE_RECIP   = 46603;

    // floor(2^LEVEL_SHIFT / 600000): quotient estimate is exact or one low
    localparam int unsigned LEVEL_SHIFT = 40;
    localparam int unsigned RECIP_W     = 21;
    localparam int unsigned LEVEL_RECIP = 1832519;

    typedef struct packed {
        logic [HUE_IN_W-1:0] hue_degrees;
        logic [PCT_IN_W-1:0] saturation_percent;
        logic [PCT_IN_W-1:0] lightness_percent;
    } hsl_pixel_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } rgb_pixel_t;

endpackage

@@ src/hsl2rgb_prep.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB front end
// Two stages: hue reduced modulo 360, saturation and lightness clamped,
// and the hi/lo HSL terms formed at full width.
// ----------------------------------------------------------------------------
module hsl2rgb_prep (
    input  logic                                  clk,
    input  logic                                  adv,
    input  hsl2rgb_pkg::hsl_pixel_t               pixel,
    output logic [hsl2rgb_pkg::HUE_W-1:0]         hue,
    output logic [hsl2rgb_pkg::TERM_W-1:0]        hi_term,
    output logic [hsl2rgb_pkg::TERM_W-1:0]        lo_term
);

    localparam int unsigned PW = hsl2rgb_pkg::PCT_W;
    localparam int unsigned TW = hsl2rgb_pkg::TERM_W;
    localparam int unsigned HW = hsl2rgb_pkg::HUE_IN_W;

    // stage 1
    logic [2*HW-1:0]                    hue_prod;
    logic [PW-1:0]                      sat_clamp;
    logic [PW-1:0]                      light_clamp;
    logic [HW-1:0]                      hue_reg;
    logic [hsl2rgb_pkg::HUE_Q_W-1:0]    hue_q_reg;
    logic [PW-1:0]                      sat_reg;
    logic [PW-1:0]                      light_reg;
    logic [TW-1:0]                      sl_reg;

    // stage 2
    logic [HW-1:0]                      hue_rem;
    logic [HW-1:0]                      hue_mod;
    logic [TW:0]                        l100;
    logic [TW:0]                        s100;
    logic [TW:0]                        hi_next;
    logic [TW:0]                        lo_next;
    logic [hsl2rgb_pkg::HUE_W-1:0]      hue_reg2;
    logic [TW-1:0]                      hi_reg;
    logic [TW-1:0]                      lo_reg;

    always_comb
    begin
        hue_prod    = (2*HW)'(pixel.hue_degrees) * (2*HW)'(hsl2rgb_pkg::HUE_RECIP);
        sat_clamp   = (pixel.saturation_percent > 8'(hsl2rgb_pkg::PCT_MAX))
                    ? PW'(hsl2rgb_pkg::PCT_MAX) : pixel.saturation_percent[PW-1:0];
        light_clamp = (pixel.lightness_percent > 8'(hsl2rgb_pkg::PCT_MAX))
                    ? PW'(hsl2rgb_pkg::PCT_MAX) : pixel.lightness_percent[PW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg   <= pixel.hue_degrees;
            hue_q_reg <= hue_prod[hsl2rgb_pkg::HUE_SHIFT +: hsl2rgb_pkg::HUE_Q_W];
            sat_reg   <= sat_clamp;
            light_reg <= light_clamp;
            sl_reg    <= TW'(TW'(sat_clamp) * TW'(light_clamp));
        end
    end

    always_comb
    begin
        hue_rem = hue_reg - HW'(HW'(hue_q_reg) * HW'(hsl2rgb_pkg::HUE_FULL));
        hue_mod = (hue_rem >= HW'(hsl2rgb_pkg::HUE_FULL))
                ? hue_rem - HW'(hsl2rgb_pkg::HUE_FULL) : hue_rem;
        l100    = (TW+1)'(light_reg) * (TW+1)'(hsl2rgb_pkg::PCT_MAX);
        s100    = (TW+1)'(sat_reg) * (TW+1)'(hsl2rgb_pkg::PCT_MAX);
        if (light_reg < PW'(hsl2rgb_pkg::PCT_HALF))
        begin
            hi_next = l100 + (TW+1)'(sl_reg);
            lo_next = l100 - (TW+1)'(sl_reg);
        end
        else
        begin
            hi_next = l100 + s100 - (TW+1)'(sl_reg);
            lo_next = l100 + (TW+1)'(sl_reg) - s100;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg2 <= hue_mod[hsl2rgb_pkg::HUE_W-1:0];
            hi_reg   <= hi_next[TW-1:0];
            lo_reg   <= lo_next[TW-1:0];
        end
    end

    assign hue     = hue_reg2;
    assign hi_term = hi_reg;
    assign lo_term = lo_reg;

endmodule

@@ src/hsl2rgb_chan.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB channel
// Three stages: piecewise hue ramp, scale by 255 with reciprocal quotient
// estimate, then remainder correction to the 8-bit level.
// ----------------------------------------------------------------------------
module hsl2rgb_chan (
    input  logic                                  clk,
    input  logic                                  adv,
    input  logic [hsl2rgb_pkg::HUE_W-1:0]         hue,
    input  logic [hsl2rgb_pkg::TERM_W-1:0]        hi_term,
    input  logic [hsl2rgb_pkg::TERM_W-1:0]        lo_term,
    output logic [hsl2rgb_pkg::LEVEL_W-1:0]       level
);

    localparam int unsigned TW  = hsl2rgb_pkg::TERM_W;
    localparam int unsigned RW  = hsl2rgb_pkg::RAMP_W;
    localparam int unsigned XW  = hsl2rgb_pkg::SCALED_W;
    localparam int unsigned LW  = hsl2rgb_pkg::LEVEL_W;
    localparam int unsigned HW  = hsl2rgb_pkg::HUE_W;
    localparam int unsigned TTW = 6;
    localparam int unsigned MW  = XW + hsl2rgb_pkg::RECIP_W;

    logic [TW-1:0]   span;
    logic [TTW-1:0]  ramp_t;
    logic [RW-1:0]   ramp_base;
    logic [RW-1:0]   ramp_next;
    logic [RW-1:0]   ramp_reg;

    logic [XW-1:0]   scaled;
    logic [MW-1:0]   recip_prod;
    logic [XW-1:0]   scaled_reg;
    logic [LW-1:0]   q_est_reg;

    logic [XW-1:0]   rem;
    logic [LW-1:0]   level_next;
    logic [LW-1:0]   level_reg;

    always_comb
    begin
        span = hi_term - lo_term;
        if (hue < HW'(hsl2rgb_pkg::HUE_SIXTH))
        begin
            ramp_t    = hue[TTW-1:0];
            ramp_base = RW'(lo_term) * RW'(hsl2rgb_pkg::HUE_SIXTH);
        end
        else if (hue < HW'(hsl2rgb_pkg::HUE_HALF))
        begin
            ramp_t    = '0;
            ramp_base = RW'(hi_term) * RW'(hsl2rgb_pkg::HUE_SIXTH);
        end
        else if (hue < HW'(hsl2rgb_pkg::HUE_TWO3))
        begin
            ramp_t    = TTW'(HW'(hsl2rgb_pkg::HUE_TWO3) - hue);
            ramp_base = RW'(lo_term) * RW'(hsl2rgb_pkg::HUE_SIXTH);
        end
        else
        begin
            ramp_t    = '0;
            ramp_base = RW'(lo_term) * RW'(hsl2rgb_pkg::HUE_SIXTH);
        end
        ramp_next = ramp_base + RW'(RW'(span) * RW'(ramp_t));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ramp_reg <= ramp_next;
        end
    end

    always_comb
    begin
        scaled     = {ramp_reg, 8'd0} - XW'(ramp_reg);
        recip_prod = MW'(scaled) * MW'(hsl2rgb_pkg::LEVEL_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scaled_reg <= scaled;
            q_est_reg  <= recip_prod[hsl2rgb_pkg::LEVEL_SHIFT +: LW];
        end
    end

    always_comb
    begin
        rem        = scaled_reg - XW'(XW'(q_est_reg) * XW'(hsl2rgb_pkg::RAMP_FULL));
        level_next = (rem >= XW'(hsl2rgb_pkg::RAMP_FULL)) ? q_est_reg + LW'(1) : q_est_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            level_reg <= level_next;
        end
    end

    assign level = level_reg;

endmodule

@@ src/hsl_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Input transfers pass through the two prep stages and three channel stages to rgb_data.
// Throughput: one transfer per cycle; a stall on a valid rgb result freezes all five stages.
// Reset clears the stage valid bits only; the datapath is not reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      hsl_valid,
    output logic                      hsl_stall,
    input  hsl2rgb_pkg::hsl_pixel_t   hsl_data,
    output logic                      rgb_valid,
    input  logic                      rgb_stall,
    output hsl2rgb_pkg::rgb_pixel_t   rgb_data
);

    localparam int unsigned STAGES = 5;
    localparam int unsigned HW     = hsl2rgb_pkg::HUE_W;

    logic                                 adv;
    logic [STAGES-1:0]                    stage_valid_reg;
    logic [STAGES-1:0]                    stage_valid_next;
    logic [HW-1:0]                        hue;
    logic [HW-1:0]                        hue_red;
    logic [HW-1:0]                        hue_blue;
    logic [hsl2rgb_pkg::TERM_W-1:0]       hi_term;
    logic [hsl2rgb_pkg::TERM_W-1:0]       lo_term;

    assign adv       = !(stage_valid_reg[STAGES-1] && rgb_stall);
    assign hsl_stall = !adv;
    assign rgb_valid = stage_valid_reg[STAGES-1];

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (adv)
        begin
            stage_valid_next = {stage_valid_reg[STAGES-2:0], hsl_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    hsl2rgb_prep u_prep (
        .clk     (clk),
        .adv     (adv),
        .pixel   (hsl_data),
        .hue     (hue),
        .hi_term (hi_term),
        .lo_term (lo_term)
    );

    always_comb
    begin
        hue_red  = (hue < HW'(hsl2rgb_pkg::HUE_TWO3))
                 ? hue + HW'(hsl2rgb_pkg::HUE_THIRD) : hue - HW'(hsl2rgb_pkg::HUE_TWO3);
        hue_blue = (hue >= HW'(hsl2rgb_pkg::HUE_THIRD))
                 ? hue - HW'(hsl2rgb_pkg::HUE_THIRD) : hue + HW'(hsl2rgb_pkg::HUE_TWO3);
    end

    hsl2rgb_chan u_red (
        .clk     (clk),
        .adv     (adv),
        .hue     (hue_red),
        .hi_term (hi_term),
        .lo_term (lo_term),
        .level   (rgb_data.red_level)
    );

    hsl2rgb_chan u_green (
        .clk     (clk),
        .adv     (adv),
        .hue     (hue),
        .hi_term (hi_term),
        .lo_term (lo_term),
        .level   (rgb_data.green_level)
    );

    hsl2rgb_chan u_blue (
        .clk     (clk),
        .adv     (adv),
        .hue     (hue_blue),
        .hi_term (hi_term),
        .lo_term (lo_term),
        .level   (rgb_data.blue_level)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Streams directed corner pixels and about 2000 random pixels through the
// converter with random gaps on both sides, one long result hold-off and two
// drain pauses. Each result transfer is checked field by field against an
// in-order queue of predicted RGB pixels.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 2000;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct {
        hsl2rgb_pkg::hsl_pixel_t pix;
        int unsigned             gap;
        bit                      drain;
    } hsl_job_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    hsl_valid = 1'b0;
    logic                    hsl_stall;
    hsl2rgb_pkg::hsl_pixel_t hsl_data = '0;
    logic                    rgb_valid;
    logic                    rgb_stall = 1'b0;
    hsl2rgb_pkg::rgb_pixel_t rgb_data;

    hsl_job_t                pixel_jobs_q[$];
    hsl2rgb_pkg::rgb_pixel_t rgb_expect_q[$];
    hsl_job_t                cur_job;
    bit                      have_job = 1'b0;
    bit                      hsl_taken = 1'b0;
    bit                      rgb_taken = 1'b0;
    bit                      hold_rgb = 1'b0;
    int unsigned             rgb_wait = 0;
    int unsigned             in_count = 0;
    int unsigned             out_count = 0;
    int unsigned             err_count = 0;
    int unsigned             cycle_count = 0;

    hsl_to_rgb_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsl_valid (hsl_valid),
        .hsl_stall (hsl_stall),
        .hsl_data  (hsl_data),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_data  (rgb_data)
    );

    always #5 clk = ~clk;

    function automatic logic [hsl2rgb_pkg::LEVEL_W-1:0] ramp_level(int unsigned lo,
                                                                   int unsigned hi,
                                                                   int unsigned h);
        int unsigned v;
        if (h < hsl2rgb_pkg::HUE_SIXTH)
            v = lo * hsl2rgb_pkg::HUE_SIXTH + (hi - lo) * h;
        else if (h < hsl2rgb_pkg::HUE_HALF)
            v = hi * hsl2rgb_pkg::HUE_SIXTH;
        else if (h < hsl2rgb_pkg::HUE_TWO3)
            v = lo * hsl2rgb_pkg::HUE_SIXTH + (hi - lo) * (hsl2rgb_pkg::HUE_TWO3 - h);
        else
            v = lo * hsl2rgb_pkg::HUE_SIXTH;
        return hsl2rgb_pkg::LEVEL_W'((v * 255) / hsl2rgb_pkg::RAMP_FULL);
    endfunction

    function automatic hsl2rgb_pkg::rgb_pixel_t convert_hsl(hsl2rgb_pkg::hsl_pixel_t p);
        int unsigned             h;
        int unsigned             s;
        int unsigned             l;
        int unsigned             hi;
        int unsigned             lo;
        int unsigned             h_red;
        int unsigned             h_blue;
        hsl2rgb_pkg::rgb_pixel_t c;
        h = p.hue_degrees % hsl2rgb_pkg::HUE_FULL;
        s = (p.saturation_percent > hsl2rgb_pkg::PCT_MAX)
          ? hsl2rgb_pkg::PCT_MAX : p.saturation_percent;
        l = (p.lightness_percent > hsl2rgb_pkg::PCT_MAX)
          ? hsl2rgb_pkg::PCT_MAX : p.lightness_percent;
        if (s == 0)
        begin
            c.red_level   = hsl2rgb_pkg::LEVEL_W'((l * 255) / hsl2rgb_pkg::PCT_MAX);
            c.green_level = c.red_level;
            c.blue_level  = c.red_level;
        end
        else
        begin
            if (l < hsl2rgb_pkg::PCT_HALF)
                hi = l * (hsl2rgb_pkg::PCT_MAX + s);
            else
                hi = (l + s) * hsl2rgb_pkg::PCT_MAX - s * l;
            lo = l * 2 * hsl2rgb_pkg::PCT_MAX - hi;
            h_red  = (h < hsl2rgb_pkg::HUE_TWO3)
                   ? h + hsl2rgb_pkg::HUE_THIRD : h - hsl2rgb_pkg::HUE_TWO3;
            h_blue = (h >= hsl2rgb_pkg::HUE_THIRD)
                   ? h - hsl2rgb_pkg::HUE_THIRD : h + hsl2rgb_pkg::HUE_TWO3;
            c.red_level   = ramp_level(lo, hi, h_red);
            c.green_level = ramp_level(lo, hi, h);
            c.blue_level  = ramp_level(lo, hi, h_blue);
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR %0t: result %0d %s got %0d expected %0d",
                 $realtime, out_count, what, got, want);
        err_count++;
    endtask

    task automatic queue_pixel(int unsigned hue, int unsigned sat, int unsigned lit,
                               int unsigned gap);
        hsl_job_t j;
        j.pix.hue_degrees        = hsl2rgb_pkg::HUE_IN_W'(hue);
        j.pix.saturation_percent = hsl2rgb_pkg::PCT_IN_W'(sat);
        j.pix.lightness_percent  = hsl2rgb_pkg::PCT_IN_W'(lit);
        j.gap   = gap;
        j.drain = 1'b0;
        pixel_jobs_q.push_back(j);
    endtask

    task automatic queue_pause();
        hsl_job_t j;
        j.pix   = '0;
        j.gap   = 0;
        j.drain = 1'b1;
        pixel_jobs_q.push_back(j);
    endtask

    // pixel driver
    always @(negedge clk)
    begin
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = hsl_valid && !hsl_taken;
            if (!nxt_valid)
            begin
                if (!have_job && pixel_jobs_q.size() > 0)
                begin
                    cur_job  = pixel_jobs_q.pop_front();
                    have_job = 1'b1;
                end
                if (have_job)
                begin
                    if (cur_job.drain)
                    begin
                        if (rgb_expect_q.size() == 0)
                            have_job = 1'b0;
                    end
                    else if (cur_job.gap > 0)
                    begin
                        cur_job.gap--;
                    end
                    else
                    begin
                        hsl_data <= cur_job.pix;
                        nxt_valid = 1'b1;
                        have_job  = 1'b0;
                    end
                end
            end
            hsl_valid <= nxt_valid;
        end
    end

    // result receiver stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rgb_taken)
                rgb_wait = (out_count >= 800 && out_count < 1100) ? 0 : $urandom_range(0, 3);
            if (hold_rgb)
            begin
                rgb_stall <= 1'b1;
            end
            else if (rgb_wait > 0)
            begin
                rgb_stall <= 1'b1;
                rgb_wait--;
            end
            else
            begin
                rgb_stall <= 1'b0;
            end
        end
    end

    // long hold-off on results while pixels keep coming
    initial
    begin
        wait (in_count >= 600);
        @(posedge clk);
        hold_rgb <= 1'b1;
        repeat (100) @(posedge clk);
        hold_rgb <= 1'b0;
    end

    // transfer monitor and checker
    always @(posedge clk)
    begin
        hsl2rgb_pkg::rgb_pixel_t want;
        hsl_taken <= rst_n && hsl_valid && !hsl_stall;
        rgb_taken <= rst_n && rgb_valid && !rgb_stall;
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (rgb_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected transfer, red", rgb_data.red_level, -1);
                end
                else
                begin
                    want = rgb_expect_q.pop_front();
                    if (rgb_data.red_level !== want.red_level)
                        report_mismatch("red", rgb_data.red_level, want.red_level);
                    if (rgb_data.green_level !== want.green_level)
                        report_mismatch("green", rgb_data.green_level, want.green_level);
                    if (rgb_data.blue_level !== want.blue_level)
                        report_mismatch("blue", rgb_data.blue_level, want.blue_level);
                end
                out_count++;
            end
            if (hsl_valid && !hsl_stall)
            begin
                rgb_expect_q.push_back(convert_hsl(hsl_data));
                in_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned sel;
        int unsigned hue;
        int unsigned sat;
        int unsigned lit;
        int unsigned gap;

        // hue band edges, wrap and clamps
        queue_pixel(0, 100, 50, 0);
        queue_pixel(59, 100, 50, 0);
        queue_pixel(60, 100, 50, 0);
        queue_pixel(119, 100, 50, 1);
        queue_pixel(120, 100, 50, 0);
        queue_pixel(179, 100, 50, 0);
        queue_pixel(180, 100, 50, 2);
        queue_pixel(239, 100, 50, 0);
        queue_pixel(240, 100, 50, 0);
        queue_pixel(359, 100, 50, 3);
        queue_pixel(360, 100, 50, 0);
        queue_pixel(719, 75, 25, 0);
        queue_pixel(65535, 255, 255, 0);
        queue_pixel(300, 0, 0, 0);
        queue_pixel(300, 0, 100, 1);
        queue_pixel(45, 0, 255, 0);
        queue_pixel(200, 1, 49, 0);
        queue_pixel(200, 1, 50, 0);
        queue_pixel(200, 101, 51, 2);
        queue_pixel(90, 255, 0, 0);
        queue_pixel(90, 100, 100, 0);
        queue_pixel(30, 100, 1, 0);
        queue_pixel(150, 50, 101, 0);
        queue_pixel(65280, 128, 127, 0);
        queue_pause();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                hue = $urandom_range(0, 359);
                sat = $urandom_range(0, 100);
                lit = $urandom_range(0, 100);
            end
            else if (sel < 7)
            begin
                hue = $urandom_range(0, 65535);
                sat = 0;
                lit = $urandom_range(0, 255);
            end
            else
            begin
                hue = $urandom_range(0, 65535);
                sat = $urandom_range(0, 255);
                lit = $urandom_range(0, 255);
            end
            gap = (i >= 800 && i < 1100) ? 0 : $urandom_range(0, 3);
            queue_pixel(hue, sat, lit, gap);
            if (i == 1500)
                queue_pause();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pixel_jobs_q.size() != 0 || have_job || hsl_valid)
            @(posedge clk);
        while (rgb_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/hsl2rgb_pkg.sv
src/hsl2rgb_prep.sv
src/hsl2rgb_chan.sv
src/hsl_to_rgb_converter.sv
verif/tb.sv
